[hdl/cse_pkg.sv]
// Shared types, constants and bit-order helpers for the CAN signal extractor.
package cse_pkg;

  localparam int FrameBytes = 8;
  localparam int DataW      = 64;
  localparam int PosW       = 6;
  localparam int LenW       = 7;
  localparam int NbW        = 4;
  localparam int ScaleW     = 32;
  localparam int OffsW      = 48;
  localparam int MagW       = DataW + ScaleW;
  localparam int ProdW      = MagW + 1;
  localparam int SumW       = ProdW + 1;
  localparam int TopW       = SumW - DataW + 1;
  localparam int IdxW       = 3;
  localparam int InTdataW   = 72;
  localparam int OutTdataW  = 136;

  typedef enum logic [IdxW-1:0] {
    RegStart    = 3'd0,
    RegLength   = 3'd1,
    RegMotorola = 3'd2,
    RegSigned   = 3'd3,
    RegScale    = 3'd4,
    RegOffset   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [PosW-1:0]   start;
    logic [LenW-1:0]   length;
    logic              motorola;
    logic              signed_mode;
    logic [ScaleW-1:0] scale;
    logic [OffsW-1:0]  offset;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] raw;
    logic             oor;
  } meta_t;

  typedef struct packed {
    logic [ProdW-1:0] sprod;
    logic             neg;
    meta_t            meta;
  } prod_t;

  typedef struct packed {
    logic             sat;
    logic             oor;
    logic [DataW-1:0] phys;
    logic [DataW-1:0] raw;
  } result_t;

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] r;
    r = (len > LenW'(DataW)) ? LenW'(DataW) : len;
    return r;
  endfunction

  // Reverse the bit order inside each byte, keep byte order.
  function automatic logic [DataW-1:0] byte_bitrev(input logic [DataW-1:0] d);
    logic [DataW-1:0] r;
    for (int i = 0; i < DataW / 8; i++) begin
      for (int b = 0; b < 8; b++) begin
        r[8*i+b] = d[8*i+7-b];
      end
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] bitrev(input logic [DataW-1:0] d);
    logic [DataW-1:0] r;
    for (int i = 0; i < DataW; i++) begin
      r[i] = d[DataW-1-i];
    end
    return r;
  endfunction

endpackage

[hdl/cse_gather.sv]
// Two-stage bit gather: align the signal window, then mask and reorder.
module cse_gather (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cse_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cse_pkg::DataW-1:0]   frame_data_i,
  input  logic [cse_pkg::NbW-1:0]     frame_bytes_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cse_pkg::meta_t              out_o
);

  logic [cse_pkg::NbW-1:0]   nb;
  logic [cse_pkg::LenW-1:0]  lim;
  logic [cse_pkg::LenW-1:0]  len_eff;
  logic [cse_pkg::PosW-1:0]  base;
  logic [cse_pkg::DataW-1:0] src;
  logic [cse_pkg::LenW-1:0]  avail;

  logic [cse_pkg::DataW-1:0] x_d, x_q;
  logic [cse_pkg::LenW-1:0]  k_d, k_q;
  logic                      oor_d, oor_a_q;
  logic                      vld_a_q, vld_b_q;
  logic                      rdy_a, rdy_b;

  logic [cse_pkg::DataW-1:0] masked;
  logic [cse_pkg::LenW-1:0]  rev_sh;
  cse_pkg::meta_t            meta_d, meta_q;

  assign rdy_b      = ~vld_b_q | out_ready_i;
  assign rdy_a      = ~vld_a_q | rdy_b;
  assign in_ready_o = rdy_a;

  always_comb begin
    nb      = (frame_bytes_i > cse_pkg::NbW'(cse_pkg::FrameBytes)) ?
              cse_pkg::NbW'(cse_pkg::FrameBytes) : frame_bytes_i;
    lim     = {nb, 3'b000};
    len_eff = cse_pkg::clamp_len(cfg_i.length);
    base    = cfg_i.motorola ? {cfg_i.start[5:3], ~cfg_i.start[2:0]} : cfg_i.start;
    src     = cfg_i.motorola ? cse_pkg::byte_bitrev(frame_data_i) : frame_data_i;
    x_d     = src >> base;
    avail   = (lim > {1'b0, base}) ? (lim - {1'b0, base}) : '0;
    k_d     = (len_eff < avail) ? len_eff : avail;
    oor_d   = len_eff > avail;
  end

  always_comb begin
    masked      = x_q & ~({cse_pkg::DataW{1'b1}} << k_q);
    rev_sh      = cse_pkg::LenW'(cse_pkg::DataW) - k_q;
    meta_d.raw  = cfg_i.motorola ? (cse_pkg::bitrev(masked) >> rev_sh) : masked;
    meta_d.oor  = oor_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a_q <= in_valid_i;
      end
      if (rdy_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      x_q     <= x_d;
      k_q     <= k_d;
      oor_a_q <= oor_d;
    end
    if (rdy_b) begin
      meta_q <= meta_d;
    end
  end

  assign out_valid_o = vld_b_q;
  assign out_o       = meta_q;

endmodule

[hdl/cse_mult.sv]
// Sign extension, split 64x32 magnitude multiply and product assembly.
module cse_mult (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cse_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cse_pkg::meta_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cse_pkg::prod_t out_o
);

  logic [cse_pkg::LenW-1:0]   len_eff;
  logic [cse_pkg::DataW-1:0]  ext;
  logic                       sign_bit;
  logic [cse_pkg::DataW-1:0]  val;
  logic                       neg_val;
  logic [cse_pkg::DataW-1:0]  mag_d, mag_q;
  logic                       neg_c_d, neg_c_q;
  cse_pkg::meta_t             meta_c_q, meta_d_q;

  logic [cse_pkg::ScaleW-1:0] b;
  logic [cse_pkg::DataW-1:0]  p0_d, p0_q, p1_d, p1_q;
  logic                       neg_d_q;

  logic [cse_pkg::MagW-1:0]   prod;
  cse_pkg::prod_t             res_d, res_q;

  logic vld_c_q, vld_d_q, vld_e_q;
  logic rdy_c, rdy_d, rdy_e;

  assign rdy_e      = ~vld_e_q | out_ready_i;
  assign rdy_d      = ~vld_d_q | rdy_e;
  assign rdy_c      = ~vld_c_q | rdy_d;
  assign in_ready_o = rdy_c;

  always_comb begin
    len_eff  = cse_pkg::clamp_len(cfg_i.length);
    ext      = in_i.raw | ({cse_pkg::DataW{1'b1}} << len_eff);
    sign_bit = in_i.raw[cse_pkg::PosW'(len_eff - cse_pkg::LenW'(1))];
    val      = (cfg_i.signed_mode && (len_eff != '0) &&
                (len_eff < cse_pkg::LenW'(cse_pkg::DataW)) && sign_bit) ? ext : in_i.raw;
    neg_val  = cfg_i.signed_mode && (len_eff != '0) && val[cse_pkg::DataW-1];
    mag_d    = neg_val ? (~val + cse_pkg::DataW'(1)) : val;
    neg_c_d  = neg_val ^ cfg_i.scale[cse_pkg::ScaleW-1];
  end

  always_comb begin
    b    = cfg_i.scale[cse_pkg::ScaleW-1] ? (~cfg_i.scale + cse_pkg::ScaleW'(1)) : cfg_i.scale;
    p0_d = cse_pkg::DataW'(mag_q[31:0]) * cse_pkg::DataW'(b);
    p1_d = cse_pkg::DataW'(mag_q[63:32]) * cse_pkg::DataW'(b);
  end

  always_comb begin
    prod       = cse_pkg::MagW'(p0_q) + {p1_q, 32'd0};
    res_d.sprod = neg_d_q ? ~{1'b0, prod} : {1'b0, prod};
    res_d.neg  = neg_d_q;
    res_d.meta = meta_d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else begin
      if (rdy_c) begin
        vld_c_q <= in_valid_i;
      end
      if (rdy_d) begin
        vld_d_q <= vld_c_q;
      end
      if (rdy_e) begin
        vld_e_q <= vld_d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      mag_q    <= mag_d;
      neg_c_q  <= neg_c_d;
      meta_c_q <= in_i;
    end
    if (rdy_d) begin
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      neg_d_q  <= neg_c_q;
      meta_d_q <= meta_c_q;
    end
    if (rdy_e) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_e_q;
  assign out_o       = res_q;

endmodule

[hdl/cse_sat.sv]
// Offset add with two's-complement completion and 64-bit saturation; output register.
module cse_sat (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cse_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cse_pkg::prod_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cse_pkg::result_t out_o
);

  logic [cse_pkg::SumW-1:0]  sum;
  logic [cse_pkg::TopW-1:0]  top_bits;
  logic                      fits;
  cse_pkg::result_t          res_d, res_q;
  logic                      vld_q;
  logic                      rdy;

  assign rdy        = ~vld_q | out_ready_i;
  assign in_ready_o = rdy;

  always_comb begin
    sum = {in_i.sprod[cse_pkg::ProdW-1], in_i.sprod}
        + {{(cse_pkg::SumW-cse_pkg::OffsW){cfg_i.offset[cse_pkg::OffsW-1]}}, cfg_i.offset}
        + cse_pkg::SumW'(in_i.neg);
    top_bits  = sum[cse_pkg::SumW-1:cse_pkg::DataW-1];
    fits      = (&top_bits) | ~(|top_bits);
    res_d.raw = in_i.meta.raw;
    res_d.oor = in_i.meta.oor;
    res_d.sat = ~fits;
    priority if (fits) begin
      res_d.phys = sum[cse_pkg::DataW-1:0];
    end else if (sum[cse_pkg::SumW-1]) begin
      res_d.phys = {1'b1, {(cse_pkg::DataW-1){1'b0}}};
    end else begin
      res_d.phys = {1'b0, {(cse_pkg::DataW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = res_q;

endmodule

[hdl/can_signal_extract.sv]
// Top level: configuration registers and the six-stage signal decode pipeline.
//
// Slave stream carries one CAN frame per beat; master stream returns one decoded
// signal per beat. Configuration is written through a plain write port (enable,
// register index, data); the user must do so only while the stream is idle, as the
// block does not enforce it; writes to unused indexes drop. Stages: two for the
// bit gather (window shift, then mask and Motorola reorder), three for the scale
// path (sign extension, two 32x32 partial products, product assembly) and one for
// the offset add and saturation into the output register. Throughput is one frame
// per cycle without stalls; the two 32x32 multipliers set the stage depth. Each
// stage holds its own valid bit and takes a new beat whenever it is empty or its
// successor moves, so a stalled receiver backs the pipeline up one stage at a time
// and input is still taken while bubbles remain.
// Reset clears all stage valid bits and loads the register defaults: start 0,
// length 8, Intel order, unsigned, scale 1.0, offset 0.
module can_signal_extract (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cse_pkg::IdxW-1:0]         cfg_idx_i,
  input  logic [cse_pkg::OffsW-1:0]        cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // frame_data[63:0], frame_bytes[67:64], zero pad
  input  logic [cse_pkg::InTdataW-1:0]     s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // raw bits[63:0], scaled value[127:64], out of range[128], saturated[129], zero pad
  output logic [cse_pkg::OutTdataW-1:0]    m_axis_tdata_o
);

  cse_pkg::cfg_t    cfg_q, cfg_d;
  cse_pkg::meta_t   gather_out;
  cse_pkg::prod_t   mult_out;
  cse_pkg::result_t res;
  logic             g_valid, g_ready;
  logic             m_valid, m_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cse_pkg::reg_idx_e'(cfg_idx_i))
        cse_pkg::RegStart:    cfg_d.start       = cfg_wdata_i[cse_pkg::PosW-1:0];
        cse_pkg::RegLength:   cfg_d.length      = cfg_wdata_i[cse_pkg::LenW-1:0];
        cse_pkg::RegMotorola: cfg_d.motorola    = cfg_wdata_i[0];
        cse_pkg::RegSigned:   cfg_d.signed_mode = cfg_wdata_i[0];
        cse_pkg::RegScale:    cfg_d.scale       = cfg_wdata_i[cse_pkg::ScaleW-1:0];
        cse_pkg::RegOffset:   cfg_d.offset      = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start       <= '0;
      cfg_q.length      <= cse_pkg::LenW'(8);
      cfg_q.motorola    <= 1'b0;
      cfg_q.signed_mode <= 1'b0;
      cfg_q.scale       <= cse_pkg::ScaleW'(65536);
      cfg_q.offset      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cse_gather u_gather (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .frame_data_i  (s_axis_tdata_i[cse_pkg::DataW-1:0]),
    .frame_bytes_i (s_axis_tdata_i[cse_pkg::DataW+cse_pkg::NbW-1:cse_pkg::DataW]),
    .out_valid_o   (g_valid),
    .out_ready_i   (g_ready),
    .out_o         (gather_out)
  );

  cse_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (g_valid),
    .in_ready_o  (g_ready),
    .in_i        (gather_out),
    .out_valid_o (m_valid),
    .out_ready_i (m_ready),
    .out_o       (mult_out)
  );

  cse_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (m_valid),
    .in_ready_o  (m_ready),
    .in_i        (mult_out),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {6'd0, res.sat, res.oor, res.phys, res.raw};

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output register");

  a_sat_clips_to_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.sat) |->
      (res.phys == {1'b1, {(cse_pkg::DataW-1){1'b0}}} ||
       res.phys == {1'b0, {(cse_pkg::DataW-1){1'b1}}}))
    else $error("saturated beat without a limit value");

  a_chain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tready_i && g_ready) |-> s_axis_tready_o)
    else $error("gather stage blocked while downstream drains");

endmodule
